// ===== src/tlc_pkg.sv =====
// Package for the text line and token counter.
// Word types for both channels, byte constants and register map.
// No dependencies.
package tlc_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int OUT_WIDTH       = 32;
	localparam int APB_DATA_WIDTH  = 32;
	localparam int APB_ADDR_WIDTH  = 3;
	localparam int REG_IDX_WIDTH   = 1;

	localparam logic [7:0] NL_BYTE       = 8'h0A;
	localparam logic [7:0] SP_BYTE       = 8'h20;
	localparam logic [7:0] TAB_BYTE      = 8'h09;
	localparam logic [7:0] COMMENT_RESET = 8'h25;

	// register index, byte address is 4 * index
	localparam logic [REG_IDX_WIDTH-1:0] REG_COMMENT_CHAR = 1'b0;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       has_byte;
		logic       is_last;
	} src_word_t;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] line_count;
		logic [OUT_WIDTH-1:0] token_count;
		logic [OUT_WIDTH-1:0] max_line_tokens;
		logic [OUT_WIDTH-1:0] byte_count;
	} res_word_t;

endpackage

// ===== src/text_line_token_counter.sv =====
// Top level of the text line and token counter: APB register and counting core.
// Depends on tlc_pkg and tlc_core.
//
// channel   dir  handshake          word
// src       in   src_valid/stall    src_word_t: byte_value, has_byte, is_last
// res       out  res_valid/stall    res_word_t: four 32-bit counts
// apb       in   psel/penable       comment_char at byte address 0
//
// One word a cycle while src_stall is low; a word goes through an input register and,
// if it ends the file, its counts are then registered in the result register.
// Reset clears the valid flags of both stages and all counters; comment_char returns to '%'.
// While a result is stalled, words that end no file keep flowing; an end word
// waits in the input register, and the source sees stall, until it is taken.
module text_line_token_counter
	import tlc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_WIDTH-1:0] paddr,
	input  logic [APB_DATA_WIDTH-1:0] pwdata,
	output logic [APB_DATA_WIDTH-1:0] prdata,
	output logic                      pready,
	input  logic                      src_valid,
	output logic                      src_stall,
	input  src_word_t                 src_word,
	output logic                      res_valid,
	input  logic                      res_stall,
	output res_word_t                 res_word
);

	logic [7:0]               comment_char_q;
	logic [REG_IDX_WIDTH-1:0] reg_idx;
	logic                     reg_wr;

	assign reg_idx = paddr[APB_ADDR_WIDTH-1:2];
	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comment_char_q <= COMMENT_RESET;
		end else if (reg_wr && reg_idx == REG_COMMENT_CHAR) begin
			comment_char_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_COMMENT_CHAR) begin
			prdata = APB_DATA_WIDTH'(comment_char_q);
		end
	end

	tlc_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.comment_char (comment_char_q),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.src_word     (src_word),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res_word     (res_word)
	);

endmodule

// ===== src/tlc_core.sv =====
// Counting core: input stage, per-file counters and result register.
// Depends on tlc_pkg.
module tlc_core
	import tlc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] comment_char,
	input  logic       src_valid,
	output logic       src_stall,
	input  src_word_t  src_word,
	output logic       res_valid,
	input  logic       res_stall,
	output res_word_t  res_word
);

	typedef enum logic [1:0] {
		LK_IDLE    = 2'd0,
		LK_NORMAL  = 2'd1,
		LK_COMMENT = 2'd2
	} line_kind_t;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	function automatic cnt_t sat_inc(input cnt_t v, input logic en);
		if (en && !(&v)) begin
			return v + COUNT_WIDTH'(1);
		end
		return v;
	endfunction

	function automatic logic [OUT_WIDTH-1:0] sat_out(input cnt_t v);
		logic [63:0] w;
		w = 64'(v);
		if (|w[63:OUT_WIDTH]) begin
			return '1;
		end
		return w[OUT_WIDTH-1:0];
	endfunction

	logic       s1_valid_q;
	src_word_t  s1_word_q;
	logic       s1_adv;
	logic       src_take;
	logic       step;

	logic       inside_q;
	line_kind_t kind_q;
	cnt_t       lines_q, tokens_q, tl_q, most_q, bytes_q;

	logic       n_inside;
	line_kind_t n_kind;
	cnt_t       n_lines, n_tokens, n_tl, n_most, n_bytes;
	cnt_t       tl_closed;
	cnt_t       f_tokens, f_tl, f_most;

	logic       res_valid_q;
	res_word_t  res_word_q;

	// a word that closes a file waits while the result register is held
	assign s1_adv    = !(s1_word_q.is_last && res_valid_q && res_stall);
	assign src_stall = s1_valid_q && !s1_adv;
	assign src_take  = src_valid && !src_stall;
	assign step      = s1_valid_q && s1_adv;

	always_comb begin
		n_inside  = inside_q;
		n_kind    = kind_q;
		n_lines   = lines_q;
		n_tokens  = tokens_q;
		n_tl      = tl_q;
		n_most    = most_q;
		n_bytes   = bytes_q;
		tl_closed = tl_q;
		if (s1_word_q.has_byte) begin
			n_bytes = sat_inc(bytes_q, 1'b1);
			priority if (s1_word_q.byte_value == comment_char && kind_q == LK_IDLE) begin
				n_kind = LK_COMMENT;
			end else if (s1_word_q.byte_value == NL_BYTE) begin
				if (kind_q != LK_COMMENT) begin
					n_lines   = sat_inc(lines_q, 1'b1);
					n_tokens  = sat_inc(tokens_q, inside_q);
					tl_closed = sat_inc(tl_q, inside_q);
				end
				n_inside = 1'b0;
				n_kind   = LK_IDLE;
				n_most   = (most_q < tl_closed) ? tl_closed : most_q;
				n_tl     = '0;
			end else if (s1_word_q.byte_value == SP_BYTE ||
					s1_word_q.byte_value == TAB_BYTE) begin
				n_tokens = sat_inc(tokens_q, inside_q);
				n_tl     = sat_inc(tl_q, inside_q);
				n_inside = 1'b0;
			end else begin
				if (kind_q != LK_COMMENT) begin
					n_inside = 1'b1;
					n_kind   = LK_NORMAL;
				end
			end
		end
		// end of file: close any open token and fold the last line in
		f_tokens = sat_inc(n_tokens, n_inside);
		f_tl     = sat_inc(n_tl, n_inside);
		f_most   = (n_most < f_tl) ? f_tl : n_most;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			inside_q    <= 1'b0;
			kind_q      <= LK_IDLE;
			lines_q     <= '0;
			tokens_q    <= '0;
			tl_q        <= '0;
			most_q      <= '0;
			bytes_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (src_take) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (step) begin
				if (s1_word_q.is_last) begin
					inside_q <= 1'b0;
					kind_q   <= LK_IDLE;
					lines_q  <= '0;
					tokens_q <= '0;
					tl_q     <= '0;
					most_q   <= '0;
					bytes_q  <= '0;
				end else begin
					inside_q <= n_inside;
					kind_q   <= n_kind;
					lines_q  <= n_lines;
					tokens_q <= n_tokens;
					tl_q     <= n_tl;
					most_q   <= n_most;
					bytes_q  <= n_bytes;
				end
			end
			if (step && s1_word_q.is_last) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_take) begin
			s1_word_q <= src_word;
		end
		if (step && s1_word_q.is_last) begin
			res_word_q.line_count      <= sat_out(n_lines);
			res_word_q.token_count     <= sat_out(f_tokens);
			res_word_q.max_line_tokens <= sat_out(f_most);
			res_word_q.byte_count      <= sat_out(n_bytes);
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for text_line_token_counter: words of file bytes go in, count words
// come out and are checked against a line/token tally kept here, over several comment_char
// settings. Depends on tlc_pkg and the text_line_token_counter RTL.
module testbench;
	import tlc_pkg::*;

	typedef enum logic [1:0] {LK_NONE, LK_TEXT, LK_COMMENT} line_kind_t;

	typedef struct packed {
		src_word_t w;
		logic      fixed;
		res_word_t res;
	} dir_row_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [APB_ADDR_WIDTH-1:0] paddr = '0;
	logic [APB_DATA_WIDTH-1:0] pwdata = '0;
	logic [APB_DATA_WIDTH-1:0] prdata;
	logic                      pready;
	logic                      src_valid = 1'b0;
	logic                      src_stall;
	src_word_t                 src_word = '0;
	logic                      res_valid;
	logic                      res_stall = 1'b0;
	res_word_t                 res_word;

	text_line_token_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word(src_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word)
	);

	int          errors = 0;
	res_word_t   pending_counts[$];
	dir_row_t    dir_rows[$];
	logic [7:0]  cmt_settings[7];
	int          burst_left = 0;
	int          stall_mode = 0;
	int          stall_left = 0;
	res_word_t   want;

	// tally state
	logic [7:0]  cmt_char = COMMENT_RESET;
	line_kind_t  kind = LK_NONE;
	logic        in_tok = 1'b0;
	logic [31:0] n_lines = '0;
	logic [31:0] n_tokens = '0;
	logic [31:0] n_line_tok = '0;
	logic [31:0] n_most = '0;
	logic [31:0] n_bytes = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [31:0] sat_inc(logic [31:0] a, logic b);
		return (&a) ? a : a + 32'(b);
	endfunction

	function void end_token();
		n_tokens = sat_inc(n_tokens, in_tok);
		n_line_tok = sat_inc(n_line_tok, in_tok);
		in_tok = 1'b0;
	endfunction

	function void fold_most();
		if (n_most < n_line_tok)
			n_most = n_line_tok;
	endfunction

	// Returns 1 when the word ends a file; r then holds its counts.
	function bit tally_word(input src_word_t w, output res_word_t r);
		r = '0;
		if (w.has_byte) begin
			n_bytes = sat_inc(n_bytes, 1'b1);
			// comment test wins even over newline and blanks
			if (w.byte_value == cmt_char && kind == LK_NONE) begin
				kind = LK_COMMENT;
			end else if (w.byte_value == NL_BYTE) begin
				if (kind != LK_COMMENT) begin
					n_lines = sat_inc(n_lines, 1'b1);
					end_token();
				end
				in_tok = 1'b0;
				kind = LK_NONE;
				fold_most();
				n_line_tok = '0;
			end else if (w.byte_value == SP_BYTE || w.byte_value == TAB_BYTE) begin
				end_token();
			end else if (kind != LK_COMMENT) begin
				in_tok = 1'b1;
				kind = LK_TEXT;
			end
		end
		if (!w.is_last)
			return 1'b0;
		end_token();
		fold_most();
		r.line_count = n_lines;
		r.token_count = n_tokens;
		r.max_line_tokens = n_most;
		r.byte_count = n_bytes;
		in_tok = 1'b0;
		kind = LK_NONE;
		n_lines = '0;
		n_tokens = '0;
		n_line_tok = '0;
		n_most = '0;
		n_bytes = '0;
		return 1'b1;
	endfunction

	function void check_field(string name, logic [31:0] exp_val, logic [31:0] got);
		if (got !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got);
			errors++;
		end
	endfunction

	task automatic add_row(input logic [7:0] b, input bit has, input bit last, input bit fixed,
		input int lines, input int toks, input int most, input int nbytes);
		dir_row_t row;
		row.w = {b, has, last};
		row.fixed = fixed;
		row.res = {32'(lines), 32'(toks), 32'(most), 32'(nbytes)};
		dir_rows.push_back(row);
	endtask

	// Sender: bursts of random length with random gaps between them.
	task automatic send_word(input src_word_t w, input bit fixed, input res_word_t fixed_res);
		res_word_t r;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				src_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		src_valid <= 1'b1;
		src_word <= w;
		do @(posedge clk); while (src_stall);
		if (tally_word(w, r))
			pending_counts.push_back(fixed ? fixed_res : r);
	endtask

	task drain_results();
		src_valid <= 1'b0;
		while (pending_counts.size() != 0)
			@(posedge clk);
		// a word that ends no file may still be in the pipe
		repeat (4) @(posedge clk);
	endtask

	task set_comment_char(input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_COMMENT_CHAR, 2'b00};
		pwdata <= {24'b0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task check_comment_char(input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {REG_COMMENT_CHAR, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {24'b0, v}) begin
			$error("comment_char: expected %0d, got %0d", {24'b0, v}, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return SP_BYTE;
		if (r < 20)
			return TAB_BYTE;
		if (r < 32)
			return NL_BYTE;
		if (r < 40)
			return cmt_char;
		if (r < 75)
			return 8'($urandom_range(97, 122));
		return 8'($urandom);
	endfunction

	// One random file; counted excludes the ignored no-byte words.
	task automatic send_file(output int counted);
		int n;
		src_word_t w;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				w = {8'($urandom), 1'b0, 1'b0};
				send_word(w, 1'b0, '0);
			end
			w = {pick_byte(), 1'b1, 1'b0};
			send_word(w, 1'b0, '0);
		end
		w = {pick_byte(), 1'($urandom_range(0, 1)), 1'b1};
		send_word(w, 1'b0, '0);
		counted = n + 1;
	endtask

	// Result checker and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_counts.size() == 0) begin
				$error("result word with no file pending");
				errors++;
			end else begin
				want = pending_counts.pop_front();
				check_field("line_count", want.line_count, res_word.line_count);
				check_field("token_count", want.token_count, res_word.token_count);
				check_field("max_line_tokens", want.max_line_tokens, res_word.max_line_tokens);
				check_field("byte_count", want.byte_count, res_word.byte_count);
			end
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			2: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= ($urandom_range(0, 19) != 0);
		endcase
	end

	initial begin
		int counted;
		int k;
		// empty file, then an idle word, then three short files
		add_row(8'hFF, 1'b0, 1'b1, 1'b1, 0, 0, 0, 0);
		add_row(8'h00, 1'b0, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row("a", 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row(TAB_BYTE, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row("b", 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row(SP_BYTE, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row(NL_BYTE, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row("%", 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row("c", 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row(NL_BYTE, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row(8'h00, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row(8'hFF, 1'b1, 1'b1, 1'b1, 1, 3, 2, 10);
		add_row(SP_BYTE, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row("%", 1'b0, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row("%", 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row("x", 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row(NL_BYTE, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row("y", 1'b1, 1'b1, 1'b1, 0, 1, 1, 5);
		add_row(NL_BYTE, 1'b1, 1'b0, 1'b0, 0, 0, 0, 0);
		add_row(NL_BYTE, 1'b1, 1'b1, 1'b1, 2, 0, 0, 2);

		cmt_settings[0] = 8'h00;
		cmt_settings[1] = 8'hFF;
		cmt_settings[2] = NL_BYTE;
		cmt_settings[3] = SP_BYTE;
		cmt_settings[4] = TAB_BYTE;
		cmt_settings[5] = 8'($urandom);
		cmt_settings[6] = COMMENT_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_comment_char(COMMENT_RESET);

		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].res);
		drain_results();

		for (int p = 0; p < 7; p++) begin
			set_comment_char(cmt_settings[p]);
			check_comment_char(cmt_settings[p]);
			cmt_char = cmt_settings[p];
			counted = 0;
			while (counted < 130) begin
				send_file(k);
				counted += k;
			end
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
